@@ src/iawsd_pkg.sv @@
// Shared constants, request and status codes, and the cell control bundle.
package iawsd_pkg;

  // Store size and derived widths.
  localparam int CAPACITY = 64;
  localparam int DATA_W   = 32;
  localparam int IDX_W    = 6;
  localparam int OCNT_W   = 7;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int CMP_W    = (CNT_W > IDX_W) ? CNT_W : IDX_W;

  // Request kinds.
  localparam logic [1:0] REQ_APPEND = 2'd0;
  localparam logic [1:0] REQ_REMOVE = 2'd1;
  localparam logic [1:0] REQ_READ   = 2'd2;

  // Result status codes.
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_INDEX = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;

  // Control broadcast from the top level to every cell.
  typedef struct packed {
    logic              append;
    logic              remove;
    logic              read;
    logic [CMP_W-1:0]  pos;
    logic [CMP_W-1:0]  tail;
    logic [DATA_W-1:0] value;
  } cell_ctl_t;

endpackage

@@ src/indexed_array_with_shift_delete_unit.sv @@
// Top level: packed word array built as a row of shifting cells.
// A request's result is registered and shown in the cycle after acceptance.
// One request per cycle unless the output stalls; the cells shift all later entries at once.
// A new request is taken while the previous result is being taken in the same cycle.
// Reset (rst, synchronous, active high) clears the fill count and the output valid;
// cell contents are left as they are and are never read before being written.
module indexed_array_with_shift_delete_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // value[31:0], index[37:32], zeros[39:38]
  input  logic [1:0]  s_tuser,   // req_type[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata    // read_value[31:0], status[33:32], entry_count[40:34], zeros
);

  localparam int N = iawsd_pkg::CAPACITY;
  localparam int W = iawsd_pkg::DATA_W;

  logic [iawsd_pkg::CNT_W-1:0] fill_count;
  logic [iawsd_pkg::CNT_W-1:0] fill_count_next;

  logic                         accept;
  logic [1:0]                   req_type;
  logic [W-1:0]                 value;
  logic [iawsd_pkg::IDX_W-1:0]  index;
  logic                         full;
  logic                         idx_ok;
  iawsd_pkg::cell_ctl_t         ctl;

  logic [W-1:0] words   [N];
  logic [W-1:0] rd_words[N];
  logic [W-1:0] rd_bus;

  logic [W-1:0]                  rd_value_next;
  logic [1:0]                    status_next;
  logic [W-1:0]                  out_read_value;
  logic [1:0]                    out_status;
  logic [iawsd_pkg::OCNT_W-1:0]  out_count;

  // Request unpacking.
  assign req_type = s_tuser;
  assign value    = s_tdata[31:0];
  assign index    = s_tdata[37:32];

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  assign full   = (fill_count == iawsd_pkg::CNT_W'(N));
  assign idx_ok = (iawsd_pkg::CMP_W'(index) < iawsd_pkg::CMP_W'(fill_count));

  // Control broadcast to the cells.
  always_comb begin
    ctl.append = accept && (req_type == iawsd_pkg::REQ_APPEND) && !full;
    ctl.remove = accept && (req_type == iawsd_pkg::REQ_REMOVE) && idx_ok;
    ctl.read   = (req_type == iawsd_pkg::REQ_READ) && idx_ok;
    ctl.pos    = iawsd_pkg::CMP_W'(index);
    ctl.tail   = iawsd_pkg::CMP_W'(fill_count);
    ctl.value  = value;
  end

  // The row of cells; each takes its upper neighbor's word on removal.
  for (genvar k = 0; k < N; k++) begin : g_cell
    logic [W-1:0] upper;
    if (k == N - 1) begin : g_last
      assign upper = words[k];
    end else begin : g_mid
      assign upper = words[k+1];
    end
    iawsd_cell u_cell (
      .clk        (clk),
      .cell_idx   (iawsd_pkg::CMP_W'(k)),
      .ctl        (ctl),
      .upper_word (upper),
      .word       (words[k]),
      .rd_word    (rd_words[k])
    );
  end

  // Combine the read bus; at most one cell drives a nonzero word.
  always_comb begin
    rd_bus = '0;
    for (int k = 0; k < N; k++) begin
      rd_bus = rd_bus | rd_words[k];
    end
  end

  // Next fill count and the result fields.
  always_comb begin
    fill_count_next = fill_count;
    rd_value_next   = '0;
    status_next     = iawsd_pkg::ST_OK;
    case (req_type)
      iawsd_pkg::REQ_APPEND: begin
        if (full) begin
          status_next = iawsd_pkg::ST_FULL;
        end else begin
          fill_count_next = fill_count + 1'b1;
        end
      end
      iawsd_pkg::REQ_REMOVE: begin
        if (idx_ok) begin
          fill_count_next = fill_count - 1'b1;
        end else begin
          status_next = iawsd_pkg::ST_BAD_INDEX;
        end
      end
      iawsd_pkg::REQ_READ: begin
        if (idx_ok) begin
          rd_value_next = rd_bus;
        end else begin
          status_next   = iawsd_pkg::ST_BAD_INDEX;
          rd_value_next = '1;
        end
      end
      default: begin
        status_next = iawsd_pkg::ST_OK;
      end
    endcase
  end

  // Fill count register.
  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
    end else if (accept) begin
      fill_count <= fill_count_next;
    end
  end

  // Output register; the handshake parts input and output sides.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_read_value <= rd_value_next;
      out_status     <= status_next;
      out_count      <= iawsd_pkg::OCNT_W'(fill_count_next);
    end
  end

  assign m_tdata = {7'd0, out_count, out_status, out_read_value};

  // The fill count never exceeds the capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= iawsd_pkg::CNT_W'(N))
    else $error("fill count above capacity");

  // An append into a store with room grows the count by one.
  a_append_grows: assert property (@(posedge clk) disable iff (rst)
    (accept && req_type == iawsd_pkg::REQ_APPEND && !full)
      |=> fill_count == $past(fill_count) + 1'b1)
    else $error("append did not grow the count");

  // A full status is reported only with the store at capacity.
  a_full_count: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && out_status == iawsd_pkg::ST_FULL)
      |-> out_count == iawsd_pkg::OCNT_W'(N))
    else $error("full status with a count below capacity");

  // A successful read of a valid index never reports the invalid marker status.
  a_read_status: assert property (@(posedge clk) disable iff (rst)
    (accept && req_type == iawsd_pkg::REQ_READ && idx_ok)
      |=> out_status == iawsd_pkg::ST_OK)
    else $error("valid read reported a bad status");

endmodule

@@ src/iawsd_cell.sv @@
// One storage cell of the array: holds a word, takes its upper neighbor on removal.
module iawsd_cell (
  input  logic                            clk,
  input  logic [iawsd_pkg::CMP_W-1:0]     cell_idx,
  input  iawsd_pkg::cell_ctl_t            ctl,
  input  logic [iawsd_pkg::DATA_W-1:0]    upper_word,
  output logic [iawsd_pkg::DATA_W-1:0]    word,
  output logic [iawsd_pkg::DATA_W-1:0]    rd_word
);

  logic is_tail;
  logic at_or_after;
  logic is_sel;

  assign is_tail     = (cell_idx == ctl.tail);
  assign at_or_after = (cell_idx >= ctl.pos);
  assign is_sel      = (cell_idx == ctl.pos);

  // An append lands in the first free cell; a removal pulls every later cell down.
  always_ff @(posedge clk) begin
    if (ctl.append && is_tail) begin
      word <= ctl.value;
    end else if (ctl.remove && at_or_after) begin
      word <= upper_word;
    end
  end

  // Only the addressed cell drives the shared read bus.
  assign rd_word = (ctl.read && is_sel) ? word : '0;

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for the indexed word array with shift-on-remove.
module testbench;
  import iawsd_pkg::*;

  // Request kind that the block must ignore.
  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int RANDOM_REQUESTS = 1700;
  localparam int CYCLE_LIMIT     = 200000;
  localparam int SETTLE_CYCLES   = 5;

  typedef struct {
    logic [1:0]        kind;
    logic [DATA_W-1:0] word;
    logic [IDX_W-1:0]  pos;
    int                gap;
    bit                hold;
  } request_t;

  typedef struct {
    logic [DATA_W-1:0] read_value;
    logic [1:0]        status;
    logic [OCNT_W-1:0] entry_count;
  } array_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;   // value[31:0], index[37:32], zeros[39:38]
  logic [1:0]  s_tuser = '0;   // req_type[1:0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;        // read_value[31:0], status[33:32], entry_count[40:34], zeros

  // Stimulus and prediction state.
  request_t          pending_requests[$];
  request_t          next_req;
  array_result_t     expected_results[$];
  logic [DATA_W-1:0] array_words[CAPACITY];
  int                array_fill = 0;
  int                gen_fill = 0;
  int                gap_left = 0;
  int                stall_left = 0;
  int                results_seen = 0;
  int                accepted_count = 0;
  int                outstanding = 0;
  int                error_count = 0;
  int                cycle_count = 0;

  indexed_array_with_shift_delete_unit uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #10 clk = ~clk;

  // Applies one request to the predicted array and returns the result it should give.
  function automatic array_result_t apply_request(logic [1:0] kind, logic [DATA_W-1:0] word,
                                                  logic [IDX_W-1:0] pos);
    array_result_t res;
    res.read_value = '0;
    res.status     = ST_OK;
    case (kind)
      REQ_APPEND: begin
        if (array_fill >= CAPACITY) begin
          res.status = ST_FULL;
        end else begin
          array_words[array_fill] = word;
          array_fill++;
        end
      end
      REQ_REMOVE: begin
        if (int'(pos) >= array_fill) begin
          res.status = ST_BAD_INDEX;
        end else begin
          for (int k = pos; k + 1 < array_fill; k++) array_words[k] = array_words[k + 1];
          array_fill--;
        end
      end
      REQ_READ: begin
        if (int'(pos) >= array_fill) begin
          res.status     = ST_BAD_INDEX;
          res.read_value = '1;
        end else begin
          res.read_value = array_words[pos];
        end
      end
      default: ;
    endcase
    res.entry_count = OCNT_W'(array_fill);
    return res;
  endfunction

  // Queues one request; the sender never idles in two quiet windows of the run.
  task automatic queue_request(logic [1:0] kind, logic [DATA_W-1:0] word,
                               logic [IDX_W-1:0] pos, bit hold = 1'b0);
    request_t req;
    int       n;
    n        = pending_requests.size();
    req.kind = kind;
    req.word = word;
    req.pos  = pos;
    req.hold = hold;
    req.gap  = ((n >= 300 && n < 520) || (n >= 1100 && n < 1320)) ? 0 : $urandom_range(0, 7);
    pending_requests.push_back(req);
    // Track the fill level so that indexes can be aimed at live entries.
    if (kind == REQ_APPEND && gen_fill < CAPACITY) gen_fill++;
    else if (kind == REQ_REMOVE && int'(pos) < gen_fill) gen_fill--;
  endtask

  // Mostly random words, with the signed extremes mixed in.
  function automatic logic [DATA_W-1:0] random_word();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      3: return 32'h0000_0000;
      default: return $urandom;
    endcase
  endfunction

  // Mostly a live position, sometimes any position.
  function automatic logic [IDX_W-1:0] random_index();
    int top;
    top = (gen_fill > 64) ? 64 : gen_fill;
    if (top > 0 && $urandom_range(0, 4) != 0) return IDX_W'($urandom_range(0, top - 1));
    return IDX_W'($urandom_range(0, 63));
  endfunction

  // Sender: one request at a time, with a random gap after each one.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      gap_left <= 0;
    end else if (!s_tvalid || s_tready) begin
      if (gap_left != 0) begin
        s_tvalid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending_requests.size() == 0 ||
                   (pending_requests[0].hold && (s_tvalid || outstanding != 0))) begin
        s_tvalid <= 1'b0;
      end else begin
        next_req = pending_requests.pop_front();
        s_tdata  <= {2'b00, next_req.pos, next_req.word};
        s_tuser  <= next_req.kind;
        s_tvalid <= 1'b1;
        gap_left <= next_req.gap;
      end
    end
  end

  // Receiver, checker and predictor.
  always @(posedge clk) begin
    array_result_t exp_res;
    int            errs;
    int            stall;
    bit            got_result;
    bit            took_request;
    if (rst) begin
      m_tready   <= 1'b0;
      stall_left <= 0;
    end else begin
      errs         = 0;
      got_result   = m_tvalid && m_tready;
      took_request = s_tvalid && s_tready;
      if (got_result) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result: m_tdata=%h", m_tdata);
          errs++;
        end else begin
          exp_res = expected_results.pop_front();
          if (m_tdata[31:0] !== exp_res.read_value) begin
            $error("read_value: expected %0d, got %0d",
                   $signed(exp_res.read_value), $signed(m_tdata[31:0]));
            errs++;
          end
          if (m_tdata[33:32] !== exp_res.status) begin
            $error("status: expected %0d, got %0d", exp_res.status, m_tdata[33:32]);
            errs++;
          end
          if (m_tdata[40:34] !== exp_res.entry_count) begin
            $error("entry_count: expected %0d, got %0d", exp_res.entry_count, m_tdata[40:34]);
            errs++;
          end
        end
        results_seen <= results_seen + 1;
        // Draw the stall before the next result; none in the quiet windows.
        if ((results_seen >= 300 && results_seen < 500) ||
            (results_seen >= 1100 && results_seen < 1300)) stall = 0;
        else stall = $urandom_range(0, 7);
        stall_left <= stall;
        m_tready   <= (stall == 0);
      end else if (!m_tready) begin
        if (stall_left <= 1) m_tready <= 1'b1;
        stall_left <= (stall_left > 0) ? stall_left - 1 : 0;
      end
      if (took_request) begin
        expected_results.push_back(apply_request(s_tuser, s_tdata[31:0], s_tdata[37:32]));
      end
      accepted_count <= accepted_count + int'(took_request);
      outstanding    <= outstanding + int'(took_request) - int'(got_result);
      error_count    <= error_count + errs;
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  // Stimulus and end of run.
  initial begin
    int total;
    int mode;
    int pick;
    // Empty array: invalid read and remove.
    queue_request(REQ_READ, random_word(), 6'd0);
    queue_request(REQ_REMOVE, random_word(), 6'd0);
    // Signed extremes stored and read back.
    queue_request(REQ_APPEND, 32'h7fff_ffff, 6'd63);
    queue_request(REQ_APPEND, 32'h8000_0000, 6'd0);
    queue_request(REQ_APPEND, 32'h0000_0000, 6'd63);
    queue_request(REQ_APPEND, 32'hffff_ffff, 6'd0);
    queue_request(REQ_READ, random_word(), 6'd0);
    queue_request(REQ_READ, random_word(), 6'd3);
    queue_request(REQ_READ, random_word(), 6'd4);
    queue_request(REQ_READ, random_word(), 6'd63);
    // Remove from the middle, then the last entry, then out of range.
    queue_request(REQ_REMOVE, random_word(), 6'd1);
    queue_request(REQ_READ, random_word(), 6'd1);
    queue_request(REQ_READ, random_word(), 6'd2);
    queue_request(REQ_REMOVE, random_word(), 6'd2);
    queue_request(REQ_REMOVE, random_word(), 6'd63);
    // The unused kind changes nothing.
    queue_request(REQ_UNUSED, 32'hffff_ffff, 6'd63);
    queue_request(REQ_READ, random_word(), 6'd1);
    // Remove from the front until empty, then one more.
    queue_request(REQ_REMOVE, random_word(), 6'd0);
    queue_request(REQ_REMOVE, random_word(), 6'd0);
    queue_request(REQ_REMOVE, random_word(), 6'd0);
    queue_request(REQ_READ, random_word(), 6'd0);
    queue_request(REQ_UNUSED, 32'h0000_0000, 6'd0);

    // Random part: phases that fill the array, drain it, and churn it.
    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      mode = (n / 120) % 3;
      pick = $urandom_range(0, 99);
      if (pick == 99) begin
        queue_request(REQ_UNUSED, random_word(), IDX_W'($urandom_range(0, 63)));
      end else if ((mode == 0 && pick < 88) || (mode == 1 && pick < 15) ||
                   (mode == 2 && pick < 40)) begin
        queue_request(REQ_APPEND, random_word(), IDX_W'($urandom_range(0, 63)),
                      n == 700 || n == 1500);
      end else if ((mode == 0 && pick < 93) || (mode == 1 && pick < 75) ||
                   (mode == 2 && pick < 70)) begin
        queue_request(REQ_REMOVE, random_word(), random_index());
      end else begin
        queue_request(REQ_READ, random_word(), random_index());
      end
    end
    total = pending_requests.size();

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    do @(posedge clk); while (accepted_count != total || outstanding != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

@@ indexed_array_with_shift_delete_unit.f @@
src/iawsd_pkg.sv
src/iawsd_cell.sv
src/indexed_array_with_shift_delete_unit.sv
tb/testbench.sv
